// ----- sv/urb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urb_pkg
// Types and command codes shared by the UART ring buffer block.
// ----------------------------------------------------------------------------
package urb_pkg;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_RX_IRQ = 2'd2;
	localparam logic [1:0] CMD_TX_IRQ = 2'd3;

	localparam logic [1:0] IRQ_RX_ONLY = 2'b01;
	localparam logic [1:0] IRQ_BOTH    = 2'b11;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic       extra_valid;
		logic [7:0] extra_byte;
		logic       fifo_room;
	} item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic [1:0]  irq_enable;
		logic        tx_overflow;
		logic        rx_overflow;
		logic        byte_lost;
		logic [31:0] rx_irq_count;
		logic [31:0] tx_irq_count;
		logic [31:0] sent_count;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/uart_interrupt_ring_buffers_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_interrupt_ring_buffers_top
// Transmit and receive byte rings between software and a serial FIFO.
// ----------------------------------------------------------------------------
// Usage:
// - command channel (cmd_valid / cmd_stall / cmd) takes one word per
//   put, get, receive interrupt or transmit-empty interrupt
// - response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   word per command, in order
// - a command passes from acceptance through the execute state (and a
//   second write state for a receive interrupt with a second byte) to
//   the output state, which loads its response into the output register;
//   the next command is taken once the previous one has reached it
// - the rings live in two RAMs with a registered read; the read
//   at acceptance, the update cycle and the extra write of a second
//   received byte set the item time
// - reset clears pointers, counters and the interrupt enable; ring
//   contents are not cleared and need no clearing pass
// - while the receiver stalls, the response holds in the output register
//   and one further command can be processed behind it
// ----------------------------------------------------------------------------
module uart_interrupt_ring_buffers_top #(
	parameter int TX_DEPTH = 1024,
	parameter int RX_DEPTH = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire urb_pkg::item_t  cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output urb_pkg::result_t     rsp
);

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_RX2  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       tx_overflow;
		logic       rx_overflow;
		logic       byte_lost;
	} partial_t;

	state_t         state_q, state_d;
	urb_pkg::item_t item_q;
	partial_t       res_q, res_d;

	logic [TX_AW-1:0] tx_wr_q, tx_rd_q, tx_wr_d, tx_rd_d;
	logic [RX_AW-1:0] rx_wr_q, rx_rd_q, rx_wr_d, rx_rd_d;
	logic [1:0]       irq_q, irq_d;
	logic [31:0]      rx_cnt_q, tx_cnt_q, sent_q;
	logic [31:0]      rx_cnt_d, tx_cnt_d, sent_d;

	logic [TX_AW-1:0] tx_wr_nxt, tx_rd_nxt;
	logic [RX_AW-1:0] rx_wr_nxt, rx_rd_nxt;
	logic             tx_full, tx_empty, rx_full, rx_empty;

	logic       tx_we, rx_we;
	logic [7:0] rx_wdata;
	logic [7:0] tx_rdata, rx_rdata;

	logic accept, out_load;

	urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_we),
		.wr_addr (tx_wr_q),
		.wr_data (item_q.data_byte),
		.rd_addr (tx_rd_q),
		.rd_data (tx_rdata)
	);

	urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_we),
		.wr_addr (rx_wr_q),
		.wr_data (rx_wdata),
		.rd_addr (rx_rd_q),
		.rd_data (rx_rdata)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_load  = (state_q == ST_OUT) && (!rsp_valid || !rsp_stall);

	assign tx_wr_nxt = (tx_wr_q == TX_LAST) ? '0 : tx_wr_q + 1'b1;
	assign tx_rd_nxt = (tx_rd_q == TX_LAST) ? '0 : tx_rd_q + 1'b1;
	assign rx_wr_nxt = (rx_wr_q == RX_LAST) ? '0 : rx_wr_q + 1'b1;
	assign rx_rd_nxt = (rx_rd_q == RX_LAST) ? '0 : rx_rd_q + 1'b1;

	assign tx_full  = (tx_wr_nxt == tx_rd_q);
	assign tx_empty = (tx_wr_q == tx_rd_q);
	assign rx_full  = (rx_wr_nxt == rx_rd_q);
	assign rx_empty = (rx_wr_q == rx_rd_q);

	assign tx_we = (state_q == ST_EXEC) && (item_q.command == urb_pkg::CMD_PUT) && !tx_full;
	assign rx_we = ((state_q == ST_EXEC) && (item_q.command == urb_pkg::CMD_RX_IRQ)
		|| (state_q == ST_RX2)) && !rx_full;
	assign rx_wdata = (state_q == ST_RX2) ? item_q.extra_byte : item_q.data_byte;

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		tx_wr_d  = tx_wr_q;
		tx_rd_d  = tx_rd_q;
		rx_wr_d  = rx_wr_q;
		rx_rd_d  = rx_rd_q;
		irq_d    = irq_q;
		rx_cnt_d = rx_cnt_q;
		tx_cnt_d = tx_cnt_q;
		sent_d   = sent_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_d   = '0;
				state_d = ST_OUT;
				unique case (item_q.command)
					urb_pkg::CMD_PUT: begin
						// a push always leaves the ring non-empty, so room alone decides the send
						if (tx_full) begin
							res_d.tx_overflow = 1'b1;
						end else begin
							tx_wr_d = tx_wr_nxt;
						end
						if (item_q.fifo_room) begin
							res_d.send_valid = 1'b1;
							// empty ring: the byte just written goes straight out
							res_d.send_byte  = tx_empty ? item_q.data_byte : tx_rdata;
							tx_rd_d          = tx_rd_nxt;
							sent_d           = sent_q + 32'd1;
						end
						irq_d = urb_pkg::IRQ_BOTH;
					end
					urb_pkg::CMD_GET: begin
						if (!rx_empty) begin
							res_d.read_valid = 1'b1;
							res_d.read_byte  = rx_rdata;
							rx_rd_d          = rx_rd_nxt;
						end
					end
					urb_pkg::CMD_RX_IRQ: begin
						rx_cnt_d = rx_cnt_q + 32'd1;
						if (rx_full) begin
							res_d.rx_overflow = 1'b1;
						end else begin
							rx_wr_d = rx_wr_nxt;
						end
						irq_d = irq_q | urb_pkg::IRQ_RX_ONLY;
						if (item_q.extra_valid) begin
							state_d = ST_RX2;
						end
					end
					urb_pkg::CMD_TX_IRQ: begin
						tx_cnt_d = tx_cnt_q + 32'd1;
						irq_d    = tx_empty ? urb_pkg::IRQ_RX_ONLY : urb_pkg::IRQ_BOTH;
						if (!tx_empty) begin
							tx_rd_d = tx_rd_nxt;
							if (tx_rd_nxt == tx_wr_q) begin
								irq_d = urb_pkg::IRQ_RX_ONLY;
							end
							if (item_q.fifo_room) begin
								res_d.send_valid = 1'b1;
								res_d.send_byte  = tx_rdata;
								sent_d           = sent_q + 32'd1;
							end else begin
								res_d.byte_lost = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			ST_RX2: begin
				if (rx_full) begin
					res_d.rx_overflow = 1'b1;
				end else begin
					rx_wr_d = rx_wr_nxt;
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tx_wr_q  <= '0;
			tx_rd_q  <= '0;
			rx_wr_q  <= '0;
			rx_rd_q  <= '0;
			irq_q    <= '0;
			rx_cnt_q <= '0;
			tx_cnt_q <= '0;
			sent_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			tx_wr_q  <= tx_wr_d;
			tx_rd_q  <= tx_rd_d;
			rx_wr_q  <= rx_wr_d;
			rx_rd_q  <= rx_rd_d;
			irq_q    <= irq_d;
			rx_cnt_q <= rx_cnt_d;
			tx_cnt_q <= tx_cnt_d;
			sent_q   <= sent_d;
			if (out_load) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		res_q <= res_d;
		if (out_load) begin
			rsp.send_valid   <= res_q.send_valid;
			rsp.send_byte    <= res_q.send_byte;
			rsp.read_valid   <= res_q.read_valid;
			rsp.read_byte    <= res_q.read_byte;
			rsp.irq_enable   <= irq_q;
			rsp.tx_overflow  <= res_q.tx_overflow;
			rsp.rx_overflow  <= res_q.rx_overflow;
			rsp.byte_lost    <= res_q.byte_lost;
			rsp.rx_irq_count <= rx_cnt_q;
			rsp.tx_irq_count <= tx_cnt_q;
			rsp.sent_count   <= sent_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/urb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module urb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire
